FILE: hdl/rbcr_pkg.sv
// Shared types and constants for the red boost color remap pipeline.
package rbcr_pkg;

    localparam int CH_W      = 8;                      // one color channel
    localparam int CH_MAX    = 255;                    // largest channel value
    localparam int FACTOR_W  = 10;                     // recolor_factor width
    localparam int THRESH_W  = 9;                      // hue_threshold / mono_ignore width
    localparam int CFG_DW    = 10;                     // widest register
    localparam int X_W       = 12;                     // excess fed to a spill unit
    localparam int SQ_W      = 2 * X_W + 1;            // x*x plus rounding bias
    localparam int QE_W      = SQ_W + 9 - 16;          // quotient estimate width
    localparam int SPILL_W   = 17;                     // spill amount width
    localparam int DIV_BIAS  = (CH_MAX - 1) / 2;       // half-up rounding for /255

    typedef enum logic [1:0] {
        REG_RECOLOR_FACTOR = 2'd0,
        REG_HUE_THRESHOLD  = 2'd1,
        REG_DECAY_MODE     = 2'd2,
        REG_MONO_IGNORE    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic            was_changed;
    } pix_out_t;

    typedef struct packed {
        logic [FACTOR_W-1:0] recolor_factor;
        logic [THRESH_W-1:0] hue_threshold;
        logic                decay_mode;
        logic [THRESH_W-1:0] mono_ignore;
    } cfg_t;

    // Pixel as it travels down the pipeline between the spill stages.
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            changed;
    } side_t;

endpackage

FILE: hdl/red_boost_color_remap.sv
// Top level of the red boost color remap pipeline.
// Usage:
//   s_valid/s_ready/s_data carry one RGB pixel per transaction; m_valid/m_ready/m_data
//   return the recolored pixel and a was_changed flag, one result per input, in order.
//   cfg_wr_en/cfg_index/cfg_wr_data write one register per cycle; the user must write
//   them only while the pipe is idle, which the block itself does not enforce.
// Pipeline: ten register stages (front 2, red spill 3, green 1, blue spill 3, output
//   register 1).
// Throughput: one pixel per cycle while the output is not stalled; every stage is a
//   register pair, the two squared-spill units each hold a 12x12 multiplier, a x257
//   shift-add and a single correction step.
// Stall: all stages advance together; while m_valid is high and m_ready is low
//   the whole pipe holds and s_ready drops, so nothing is dropped or repeated.
// Reset: aresetn low empties every stage and loads the register defaults
//   (factor 128, threshold 256 so no boost, linear spill, mono skip off).
module red_boost_color_remap (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rbcr_pkg::pix_in_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output rbcr_pkg::pix_out_t              m_data,
    input  logic                            cfg_wr_en,
    input  rbcr_pkg::cfg_index_t            cfg_index,
    input  logic [rbcr_pkg::CFG_DW-1:0]     cfg_wr_data
);
    import rbcr_pkg::*;

    cfg_t               cfg_reg;
    logic               en;

    logic               front_v, sa_v, gr_v, sb_v;
    side_t              front_side, sa_side, gr_side, sb_side;
    logic [X_W-1:0]     front_x, gr_x;
    logic [SPILL_W-1:0] sa_spill, sb_spill;

    logic [SPILL_W-1:0] blue_w;
    pix_out_t           out_next;
    logic               m_valid_reg;
    pix_out_t           m_data_reg;

    // Configuration registers; indexes come from the package enum.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.recolor_factor <= FACTOR_W'(128);
            cfg_reg.hue_threshold  <= THRESH_W'(256);
            cfg_reg.decay_mode     <= 1'b0;
            cfg_reg.mono_ignore    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RECOLOR_FACTOR: begin
                    cfg_reg.recolor_factor <= cfg_wr_data[FACTOR_W-1:0];
                end
                REG_HUE_THRESHOLD: begin
                    cfg_reg.hue_threshold <= cfg_wr_data[THRESH_W-1:0];
                end
                REG_DECAY_MODE: begin
                    cfg_reg.decay_mode <= cfg_wr_data[0];
                end
                REG_MONO_IGNORE: begin
                    cfg_reg.mono_ignore <= cfg_wr_data[THRESH_W-1:0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // Advance the whole pipe unless the output holds a result nobody takes.
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    rbcr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .cfg      (cfg_reg),
        .v_in     (s_valid),
        .pix_in   (s_data),
        .v_out    (front_v),
        .side_out (front_side),
        .x_out    (front_x)
    );

    // Red excess spills into green.
    rbcr_spill u_spill_red (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .decay_mode (cfg_reg.decay_mode),
        .v_in       (front_v),
        .side_in    (front_side),
        .x_in       (front_x),
        .v_out      (sa_v),
        .side_out   (sa_side),
        .spill_out  (sa_spill)
    );

    rbcr_green u_green (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .v_in     (sa_v),
        .side_in  (sa_side),
        .spill_in (sa_spill),
        .v_out    (gr_v),
        .side_out (gr_side),
        .x_out    (gr_x)
    );

    // Green deficit spills into blue.
    rbcr_spill u_spill_green (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .decay_mode (cfg_reg.decay_mode),
        .v_in       (gr_v),
        .side_in    (gr_side),
        .x_in       (gr_x),
        .v_out      (sb_v),
        .side_out   (sb_side),
        .spill_out  (sb_spill)
    );

    // Blue floor at zero, then the output register.
    always_comb begin
        blue_w               = SPILL_W'(sb_side.blue);
        out_next.red_out     = sb_side.red;
        out_next.green_out   = sb_side.green;
        out_next.was_changed = sb_side.changed;
        if (sb_spill > blue_w) begin
            out_next.blue_out = '0;
        end else begin
            out_next.blue_out = sb_side.blue - sb_spill[CH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= sb_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hdl/rbcr_front.sv
// Front end: skip and boost decision, red scaling, saturation and excess.
module rbcr_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  rbcr_pkg::cfg_t            cfg,
    input  logic                      v_in,
    input  rbcr_pkg::pix_in_t         pix_in,
    output logic                      v_out,
    output rbcr_pkg::side_t           side_out,
    output logic [rbcr_pkg::X_W-1:0]  x_out
);
    import rbcr_pkg::*;

    localparam int FAC_W  = FACTOR_W + 1;
    localparam int PROD_W = CH_W + FAC_W;
    localparam int RV_W   = PROD_W - 8;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    logic [CH_W-1:0]     d_rg, d_gb, d_br;
    logic                mono_on, skip, hue_on, boost_next;
    logic [THRESH_W-1:0] mono_span, hue_span;
    logic [16:0]         mono_tol, hue_lim;
    logic [FAC_W-1:0]    fac;
    logic [PROD_W-1:0]   prod_next;

    logic                v1_reg;
    pix_in_t             pix1_reg;
    logic                boost1_reg;
    logic [PROD_W-1:0]   prod1_reg;

    logic [PROD_W-1:0]   rnd;
    logic [RV_W-1:0]     rv, over;
    logic                sat;
    side_t               side_next;
    logic [X_W-1:0]      x_next;

    logic                v2_reg;
    side_t               side2_reg;
    logic [X_W-1:0]      x2_reg;

    // Stage 1: decisions and the red product.
    always_comb begin
        d_rg      = abs_diff(pix_in.red_in, pix_in.green_in);
        d_gb      = abs_diff(pix_in.green_in, pix_in.blue_in);
        d_br      = abs_diff(pix_in.blue_in, pix_in.red_in);
        mono_on   = !cfg.mono_ignore[THRESH_W-1] && (cfg.mono_ignore != '0);
        mono_span = THRESH_W'(256) - cfg.mono_ignore;
        mono_tol  = {mono_span, 8'h00} - 17'(mono_span);
        skip      = mono_on
                    && ({1'b0, d_rg, 8'h00} <= mono_tol)
                    && ({1'b0, d_gb, 8'h00} <= mono_tol)
                    && ({1'b0, d_br, 8'h00} <= mono_tol);
        hue_on    = !cfg.hue_threshold[THRESH_W-1];
        hue_span  = THRESH_W'(256) - cfg.hue_threshold;
        hue_lim   = {hue_span, 8'h00} - 17'(hue_span);
        boost_next = !skip && hue_on && ({1'b0, d_rg, 8'h00} < hue_lim);
        fac       = FAC_W'(256) + FAC_W'(cfg.recolor_factor);
        prod_next = PROD_W'(pix_in.red_in) * PROD_W'(fac);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pix1_reg   <= pix_in;
            boost1_reg <= boost_next;
            prod1_reg  <= prod_next;
        end
    end

    // Stage 2: round, saturate, compute excess over full scale.
    always_comb begin
        rnd  = prod1_reg + PROD_W'(128);
        rv   = rnd[PROD_W-1:8];
        sat  = rv > RV_W'(CH_MAX);
        over = rv - RV_W'(CH_MAX);
        side_next.green   = pix1_reg.green_in;
        side_next.blue    = pix1_reg.blue_in;
        side_next.changed = boost1_reg;
        if (!boost1_reg) begin
            side_next.red = pix1_reg.red_in;
        end else if (sat) begin
            side_next.red = CH_W'(CH_MAX);
        end else begin
            side_next.red = rv[CH_W-1:0];
        end
        x_next = (boost1_reg && sat) ? X_W'(over) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side2_reg <= side_next;
            x2_reg    <= x_next;
        end
    end

    assign v_out    = v2_reg;
    assign side_out = side2_reg;
    assign x_out    = x2_reg;

endmodule

FILE: hdl/rbcr_spill.sv
// Spill unit: linear or rounded x*x/255 amount, three register stages.
module rbcr_spill (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          decay_mode,
    input  logic                          v_in,
    input  rbcr_pkg::side_t               side_in,
    input  logic [rbcr_pkg::X_W-1:0]      x_in,
    output logic                          v_out,
    output rbcr_pkg::side_t               side_out,
    output logic [rbcr_pkg::SPILL_W-1:0]  spill_out
);
    import rbcr_pkg::*;

    localparam int SC_W  = SQ_W + 9;
    localparam int REM_W = QE_W + 8;

    logic [2*X_W-1:0]   sq;
    logic [SQ_W-1:0]    m_next;
    logic [SC_W-1:0]    scaled;
    logic [QE_W-1:0]    qe_next;
    logic [REM_W-1:0]   qe_x255, rem;
    logic [QE_W-1:0]    q;
    logic [SPILL_W-1:0] spill_next;

    logic               v1_reg, v2_reg, v3_reg;
    side_t              side1_reg, side2_reg, side3_reg;
    logic [X_W-1:0]     x1_reg, x2_reg;
    logic [SQ_W-1:0]    m1_reg, m2_reg;
    logic [QE_W-1:0]    qe2_reg;
    logic [SPILL_W-1:0] spill3_reg;

    // Stage 1: square plus rounding bias; floor((2x^2+255)/510) = floor((x^2+127)/255).
    always_comb begin
        sq     = (2*X_W)'(x_in) * (2*X_W)'(x_in);
        m_next = SQ_W'(sq) + SQ_W'(DIV_BIAS);
    end

    // Stage 2: quotient estimate m*257/65536, low by at most one.
    always_comb begin
        scaled  = SC_W'({m1_reg, 8'h00}) + SC_W'(m1_reg);
        qe_next = scaled[SC_W-1:16];
    end

    // Stage 3: one correction step, then pick the rule.
    always_comb begin
        qe_x255    = {qe2_reg, 8'h00} - REM_W'(qe2_reg);
        rem        = REM_W'(m2_reg) - qe_x255;
        q          = (rem >= REM_W'(CH_MAX)) ? (qe2_reg + QE_W'(1)) : qe2_reg;
        spill_next = decay_mode ? SPILL_W'(q) : SPILL_W'(x2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg  <= side_in;
            x1_reg     <= x_in;
            m1_reg     <= m_next;
            side2_reg  <= side1_reg;
            x2_reg     <= x1_reg;
            m2_reg     <= m1_reg;
            qe2_reg    <= qe_next;
            side3_reg  <= side2_reg;
            spill3_reg <= spill_next;
        end
    end

    assign v_out     = v3_reg;
    assign side_out  = side3_reg;
    assign spill_out = spill3_reg;

endmodule

FILE: hdl/rbcr_green.sv
// Green stage: subtract the red excess spill, floor at zero, emit the deficit.
module rbcr_green (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          v_in,
    input  rbcr_pkg::side_t               side_in,
    input  logic [rbcr_pkg::SPILL_W-1:0]  spill_in,
    output logic                          v_out,
    output rbcr_pkg::side_t               side_out,
    output logic [rbcr_pkg::X_W-1:0]      x_out
);
    import rbcr_pkg::*;

    logic [SPILL_W-1:0] green_w, deficit;
    side_t              side_next;
    logic [X_W-1:0]     x_next;

    logic               v_reg;
    side_t              side_reg;
    logic [X_W-1:0]     x_reg;

    always_comb begin
        green_w   = SPILL_W'(side_in.green);
        deficit   = spill_in - green_w;
        side_next = side_in;
        if (spill_in > green_w) begin
            side_next.green = '0;
            x_next          = X_W'(deficit);
        end else begin
            side_next.green = side_in.green - spill_in[CH_W-1:0];
            x_next          = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_next;
            x_reg    <= x_next;
        end
    end

    assign v_out    = v_reg;
    assign side_out = side_reg;
    assign x_out    = x_reg;

endmodule

FILE: hdl/rbcr_checker.sv
// Port-level checks for the red boost color remap pipeline, bound to the top level.
module rbcr_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input rbcr_pkg::pix_in_t            s_data,
    input logic                         m_valid,
    input logic                         m_ready,
    input rbcr_pkg::pix_out_t           m_data
);
    import rbcr_pkg::*;

    // Input side takes a pixel whenever the output is free or draining.
    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not track the output stall");

    // A stalled result holds until taken.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed or vanished");

    // Reset empties the pipe.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A refused pixel stays offered, unchanged, until it is taken.
    a_input_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_data)))
        else $error("offered pixel changed or withdrawn before acceptance");

endmodule

bind red_boost_color_remap rbcr_checker u_rbcr_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_data      (s_data),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data)
);

FILE: test/tb_red_boost_color_remap.sv
// Self-checking testbench for the red boost color remap pipeline.
`timescale 1ns / 100ps

module tb_red_boost_color_remap;
    import rbcr_pkg::*;

    localparam real HALF_PERIOD  = 1.0;
    localparam int  LONG_HOLD    = 120;     // receiver back-pressure stretch, in cycles
    localparam int  DRAIN_CYCLES = 20;      // extra wait after the last result is checked
    localparam int  RUN_PHASES   = 10;
    localparam int  PHASE_ITEMS  = 105;
    localparam int  MAX_REPORTS  = 10;

    localparam cfg_t RESET_CFG = '{10'd128, 9'd256, 1'b0, 9'd0};

    // One row of the directed script: either a full register setting or a pixel.
    // Rows with typed set carry a result that is obvious by inspection.
    typedef struct packed {
        logic     is_cfg;
        cfg_t     regs;
        pix_in_t  px;
        logic     typed;
        pix_out_t want;
    } script_row_t;

    localparam int SCRIPT_LEN = 27;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // reset registers: threshold at one, so nothing is boosted
        '{1'b0, '0, '{8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
        '{1'b0, '0, '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
        '{1'b0, '0, '{8'd255, 8'd0,   8'd0},   1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
        '{1'b0, '0, '{8'h55,  8'hAA,  8'h0F},  1'b1, '{8'h55,  8'hAA,  8'h0F,  1'b0}},
        // double red, boost anything not at the full red-green gap, linear spill
        '{1'b1, '{10'd256, 9'd0, 1'b0, 9'd0}, '0, 1'b0, '0},
        '{1'b0, '0, '{8'd255, 8'd0,   8'd0},   1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
        '{1'b0, '0, '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd0,   8'd255, 1'b1}},
        '{1'b0, '0, '{8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{1'b0, '0, '{8'd100, 8'd90,  8'd200}, 1'b0, '0},
        '{1'b0, '0, '{8'd200, 8'd150, 8'd80},  1'b0, '0},
        '{1'b0, '0, '{8'd254, 8'd0,   8'd77},  1'b1, '{8'd255, 8'd0,   8'd0,   1'b1}},
        // widest factor, squared spill
        '{1'b1, '{10'd1023, 9'd0, 1'b1, 9'd0}, '0, 1'b0, '0},
        '{1'b0, '0, '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
        '{1'b0, '0, '{8'd128, 8'd120, 8'd255}, 1'b0, '0},
        '{1'b0, '0, '{8'd40,  8'd30,  8'd200}, 1'b0, '0},
        // no boost gain, half threshold, mono skip at half
        '{1'b1, '{10'd0, 9'd128, 1'b1, 9'd128}, '0, 1'b0, '0},
        '{1'b0, '0, '{8'd128, 8'd128, 8'd128}, 1'b1, '{8'd128, 8'd128, 8'd128, 1'b0}},
        '{1'b0, '0, '{8'd200, 8'd100, 8'd150}, 1'b0, '0},
        '{1'b0, '0, '{8'd255, 8'd0,   8'd128}, 1'b0, '0},
        '{1'b0, '0, '{8'd10,  8'd0,   8'd255}, 1'b0, '0},
        // tightest mono skip, blue spill drives blue below zero
        '{1'b1, '{10'd512, 9'd200, 1'b0, 9'd255}, '0, 1'b0, '0},
        '{1'b0, '0, '{8'd255, 8'd250, 8'd253}, 1'b0, '0},
        '{1'b0, '0, '{8'd7,   8'd7,   8'd7},   1'b0, '0},
        '{1'b0, '0, '{8'd7,   8'd8,   8'd7},   1'b0, '0},
        // threshold above one and mono level at one: plain pass-through
        '{1'b1, '{10'd1, 9'd511, 1'b0, 9'd256}, '0, 1'b0, '0},
        '{1'b0, '0, '{8'd9,   8'd9,   8'd9},   1'b1, '{8'd9,   8'd9,   8'd9,   1'b0}},
        '{1'b0, '0, '{8'd255, 8'd255, 8'd0},   1'b1, '{8'd255, 8'd255, 8'd0,   1'b0}}
    };

    // Register settings for the random phases; the last two are drawn at random.
    localparam cfg_t RUN_CFGS [8] = '{
        '{10'd128,  9'd0,   1'b0, 9'd0},
        '{10'd512,  9'd0,   1'b1, 9'd0},
        '{10'd1023, 9'd64,  1'b0, 9'd200},
        '{10'd0,    9'd255, 1'b1, 9'd1},
        '{10'd300,  9'd128, 1'b1, 9'd255},
        '{10'd64,   9'd256, 1'b0, 9'd128},
        '{10'd700,  9'd511, 1'b1, 9'd256},
        '{10'd1023, 9'd0,   1'b1, 9'd511}
    };

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    pix_in_t    s_data;
    logic       m_valid;
    logic       m_ready;
    pix_out_t   m_data;
    logic       cfg_wr_en;
    cfg_index_t cfg_index;
    logic [CFG_DW-1:0] cfg_wr_data;

    // Side data that rides along with the offered pixel.
    logic     drv_typed;
    pix_out_t drv_want;

    pix_out_t owed_pixels[$];           // results still to come, oldest first
    cfg_t     cur_cfg;                  // register copy seen by the predictor
    int       mismatches = 0;
    int       pixels_in = 0;
    int       pixels_out = 0;
    int       boosted = 0;
    int       saturated = 0;
    int       settings_used = 0;
    int       holds_asked = 0;
    int       holds_done = 0;
    int       snd_idle_pct = 0;
    int       rcv_idle_pct = 0;

    red_boost_color_remap i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic int chan_gap(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Amount taken from the next channel for an excess x; squared mode rounds half up.
    function automatic int spill_take(int x, logic squared);
        return squared ? (2 * x * x + CH_MAX) / (2 * CH_MAX) : x;
    endfunction

    // Predict the recolored pixel for one input under register setting c.
    function automatic pix_out_t remap_pixel(pix_in_t px, cfg_t c);
        int       r, g, b, f, h, mi, tol, red_v, grn_v, blu_v;
        logic     skip;
        pix_out_t o;
        r  = int'(px.red_in);
        g  = int'(px.green_in);
        b  = int'(px.blue_in);
        f  = int'(c.recolor_factor);
        h  = int'(c.hue_threshold);
        mi = int'(c.mono_ignore);
        o  = '{px.red_in, px.green_in, px.blue_in, 1'b0};
        skip = 1'b0;
        // Mono skip works only strictly inside (0, 256); all three pairs must be close.
        if (mi > 0 && mi < 256) begin
            tol  = (256 - mi) * CH_MAX;
            skip = (chan_gap(r, g) * 256 <= tol) && (chan_gap(g, b) * 256 <= tol) &&
                   (chan_gap(b, r) * 256 <= tol);
        end
        // A threshold of one or more makes the right side non-positive: no boost.
        if (!skip && chan_gap(r, g) * 256 < (256 - h) * CH_MAX) begin
            red_v = (r * (256 + f) + 128) >>> 8;
            o.was_changed = 1'b1;
            if (red_v > CH_MAX) begin
                o.red_out = CH_W'(CH_MAX);
                grn_v = g - spill_take(red_v - CH_MAX, c.decay_mode);
                if (grn_v < 0) begin
                    // green runs dry: the deficit comes out of blue, floored at zero
                    blu_v = b - spill_take(-grn_v, c.decay_mode);
                    o.green_out = '0;
                    o.blue_out  = (blu_v < 0) ? '0 : CH_W'(blu_v);
                end else begin
                    o.green_out = CH_W'(grn_v);
                end
            end else begin
                o.red_out = CH_W'(red_v);
            end
        end
        return o;
    endfunction

    // Offer one pixel after an optional idle gap; return once the transaction is taken.
    task automatic offer_pixel(input pix_in_t px, input logic typed, input pix_out_t want,
                               input int gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_data    <= px;
        drv_typed <= typed;
        drv_want  <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drain the pipe, then write all four registers on consecutive cycles.
    task automatic program_regs(input cfg_t c);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (owed_pixels.size() != 0) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_RECOLOR_FACTOR;
        cfg_wr_data <= c.recolor_factor;
        @(negedge aclk);
        cfg_index   <= REG_HUE_THRESHOLD;
        cfg_wr_data <= CFG_DW'(c.hue_threshold);
        @(negedge aclk);
        cfg_index   <= REG_DECAY_MODE;
        cfg_wr_data <= CFG_DW'(c.decay_mode);
        @(negedge aclk);
        cfg_index   <= REG_MONO_IGNORE;
        cfg_wr_data <= CFG_DW'(c.mono_ignore);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        settings_used++;
    endtask

    function automatic pix_in_t red_heavy_pixel();
        pix_in_t p;
        p.red_in   = CH_W'($urandom_range(160, 255));
        p.green_in = CH_W'($urandom_range(p.red_in - 40,
                                          (p.red_in > 215) ? 255 : p.red_in + 40));
        p.blue_in  = CH_W'($urandom);
        return p;
    endfunction

    // Channel value within d of base, clipped to the channel range.
    function automatic logic [CH_W-1:0] near_value(int base, int d);
        int v;
        v = base + $urandom_range(0, 2 * d) - d;
        return (v < 0) ? '0 : (v > CH_MAX) ? CH_W'(CH_MAX) : CH_W'(v);
    endfunction

    // Scoreboard: track register writes, queue a prediction for each accepted pixel,
    // and compare each returned result with the oldest prediction.
    always @(posedge aclk) begin : score
        pix_out_t want;
        if (!aresetn) begin
            cur_cfg = RESET_CFG;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_RECOLOR_FACTOR: cur_cfg.recolor_factor = cfg_wr_data[FACTOR_W-1:0];
                    REG_HUE_THRESHOLD:  cur_cfg.hue_threshold  = cfg_wr_data[THRESH_W-1:0];
                    REG_DECAY_MODE:     cur_cfg.decay_mode     = cfg_wr_data[0];
                    REG_MONO_IGNORE:    cur_cfg.mono_ignore    = cfg_wr_data[THRESH_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                owed_pixels.push_back(drv_typed ? drv_want : remap_pixel(s_data, cur_cfg));
                pixels_in++;
            end
            if (m_valid && m_ready) begin
                pixels_out++;
                if (owed_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] result with nothing pending: r=%0d g=%0d b=%0d chg=%0b",
                                 $realtime, m_data.red_out, m_data.green_out,
                                 m_data.blue_out, m_data.was_changed);
                end else begin
                    want = owed_pixels.pop_front();
                    if (m_data.red_out !== want.red_out || m_data.green_out !== want.green_out ||
                        m_data.blue_out !== want.blue_out ||
                        m_data.was_changed !== want.was_changed) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $write("[%0t] result %0d: expected r=%0d g=%0d b=%0d chg=%0b, ",
                                   $realtime, pixels_out, want.red_out, want.green_out,
                                   want.blue_out, want.was_changed);
                            $display("got r=%0d g=%0d b=%0d chg=%0b", m_data.red_out,
                                     m_data.green_out, m_data.blue_out, m_data.was_changed);
                        end
                    end
                end
                if (m_data.was_changed === 1'b1) boosted++;
                if (m_data.was_changed === 1'b1 && m_data.red_out == CH_W'(CH_MAX)) saturated++;
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request so the pipe
    // fills and back-pressure reaches the input side.
    initial begin : receiver
        int burst;
        int hold_cycles;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_done != holds_asked) begin
                m_ready <= 1'b0;
                holds_done++;
                hold_cycles = 1;
                while (hold_cycles < LONG_HOLD) begin
                    @(negedge aclk);
                    hold_cycles++;
                end
            end else if (rcv_idle_pct != 0 && $urandom_range(1, 100) <= rcv_idle_pct) begin
                m_ready <= 1'b0;
                burst = $urandom_range(1, 12);
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #400000;
        $display("tb_red_boost_color_remap: done, errors");
        $finish;
    end

    // Stimulus: reset, directed script, then random phases under varied settings.
    initial begin : stimulus
        cfg_t    phase_cfg;
        pix_in_t px;
        int      gap;
        int      base;
        int      spread;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        drv_typed   = 1'b0;
        drv_want    = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_RECOLOR_FACTOR;
        cfg_wr_data = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed script, light random gaps on both sides.
        snd_idle_pct = 20;
        rcv_idle_pct = 20;
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            if (SCRIPT[i].is_cfg) begin
                program_regs(SCRIPT[i].regs);
            end else begin
                gap = ($urandom_range(1, 100) <= snd_idle_pct) ? $urandom_range(1, 12) : 0;
                offer_pixel(SCRIPT[i].px, SCRIPT[i].typed, SCRIPT[i].want, gap);
            end
        end

        for (int ph = 0; ph < RUN_PHASES; ph++) begin
            if (ph < 8) begin
                phase_cfg = RUN_CFGS[ph];
            end else begin
                phase_cfg.recolor_factor = FACTOR_W'($urandom_range(0, 1023));
                phase_cfg.hue_threshold  = THRESH_W'($urandom_range(0, 300));
                phase_cfg.decay_mode     = 1'($urandom_range(0, 1));
                phase_cfg.mono_ignore    = THRESH_W'($urandom_range(0, 511));
            end
            program_regs(phase_cfg);

            // Pick idle rates per phase: some phases run flat out. Phase 2 carries the
            // long receiver hold, so the sender keeps pushing there; the last is clean.
            if (ph == RUN_PHASES - 1 || ph == 2) begin
                snd_idle_pct = 0;
                rcv_idle_pct = (ph == 2) ? 10 : 0;
            end else begin
                snd_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
                rcv_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == 30) holds_asked <= holds_asked + 1;
                // Mostly pixels that reach the boost and spill paths, the rest noise.
                case ($urandom_range(0, 9))
                    0, 1, 2: px = (3 * CH_W)'($urandom);
                    3, 4, 5: begin
                        base   = $urandom_range(0, 255);
                        spread = $urandom_range(0, 20);
                        px = '{near_value(base, spread), near_value(base, spread),
                               near_value(base, spread)};
                    end
                    6, 7, 8: px = red_heavy_pixel();
                    default: px = '{$urandom_range(0, 1) ? 8'd255 : 8'd0,
                                    $urandom_range(0, 1) ? 8'd255 : 8'd0,
                                    $urandom_range(0, 1) ? 8'd255 : 8'd0};
                endcase
                gap = (snd_idle_pct != 0 && $urandom_range(1, 100) <= snd_idle_pct) ?
                      $urandom_range(1, 12) : 0;
                offer_pixel(px, 1'b0, '0, gap);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (owed_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d pixels and checked %0d results over %0d register settings.",
                 pixels_in, pixels_out, settings_used);
        $display("Boost path taken %0d times, red saturated %0d times, %0d mismatches.",
                 boosted, saturated, mismatches);
        if (mismatches == 0) begin
            $display("tb_red_boost_color_remap: done, clean");
        end else begin
            $display("tb_red_boost_color_remap: done, errors");
        end
        $finish;
    end

endmodule

FILE: red_boost_color_remap.f
hdl/rbcr_pkg.sv
hdl/rbcr_front.sv
hdl/rbcr_spill.sv
hdl/rbcr_green.sv
hdl/red_boost_color_remap.sv
hdl/rbcr_checker.sv
test/tb_red_boost_color_remap.sv
